@@ src/fixed_point_mul_div_log_unit_core_macros.svh @@
// Assertion macros used by the checker.
`ifndef FIXED_POINT_MUL_DIV_LOG_UNIT_CORE_MACROS_SVH
`define FIXED_POINT_MUL_DIV_LOG_UNIT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FPMDL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPMDL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/fpmdl_pkg.sv @@
`default_nettype none
package fpmdl_pkg;

	localparam logic [1:0] FUNC_MUL  = 2'd0;
	localparam logic [1:0] FUNC_DIV  = 2'd1;
	localparam logic [1:0] FUNC_LOG2 = 2'd2;
	localparam logic [1:0] FUNC_NLN  = 2'd3;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_DIVZ   = 2'd1;
	localparam logic [1:0] STATUS_LOGERR = 2'd2;

	localparam logic REG_FRAC_BITS = 1'b0;
	localparam logic REG_LN2       = 1'b1;

	localparam logic [6:0]  FRAC_BITS_RESET = 7'd32;
	localparam logic [63:0] LN2_RESET       = 64'h0000_0000_B172_17F7;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
	} cmd_t;

	typedef struct packed {
		logic [63:0] result;
		logic [1:0]  status;
	} rsp_t;

	// Configuration as seen by the execution side.
	typedef struct packed {
		logic [6:0]  frac_bits;
		logic [63:0] ln2_constant;
	} cfg_t;

	// Classified job handed from front to back.
	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] a;
		logic [63:0] b;
		logic [1:0]  status;
	} job_t;

endpackage
`default_nettype wire

@@ src/fpmdl_front.sv @@
`default_nettype none
module fpmdl_front #(
	parameter int WORD_WIDTH = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire                 full,
	input  fpmdl_pkg::cmd_t     cmd,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire  [63:0]         cfg_data,
	output logic                push,
	output fpmdl_pkg::job_t     job,
	output fpmdl_pkg::cfg_t     cfg
);

	localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - WORD_WIDTH);

	logic [6:0]  frac_bits_q;
	logic [63:0] ln2_q;
	logic [63:0] a_m;
	logic [63:0] b_m;
	logic        bad_prec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_bits_q <= fpmdl_pkg::FRAC_BITS_RESET;
			ln2_q       <= fpmdl_pkg::LN2_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fpmdl_pkg::REG_FRAC_BITS: frac_bits_q <= cfg_data[6:0];
				fpmdl_pkg::REG_LN2:       ln2_q       <= cfg_data;
				default:                  ;
			endcase
		end
	end

	assign a_m      = cmd.operand_a & WMASK;
	assign b_m      = cmd.operand_b & WMASK;
	assign bad_prec = (frac_bits_q == 7'd0) || (frac_bits_q > 7'(WORD_WIDTH - 1));
	assign push     = start && !full;

	// classify: flag the error cases up front so the back only executes real work
	always_comb begin
		job.func   = cmd.func;
		job.a      = a_m;
		job.b      = b_m;
		job.status = fpmdl_pkg::STATUS_OK;
		case (cmd.func)
			fpmdl_pkg::FUNC_DIV: begin
				if (b_m == 64'd0) job.status = fpmdl_pkg::STATUS_DIVZ;
			end
			fpmdl_pkg::FUNC_LOG2, fpmdl_pkg::FUNC_NLN: begin
				if (bad_prec || a_m == 64'd0) job.status = fpmdl_pkg::STATUS_LOGERR;
			end
			default: ;
		endcase
	end

	assign cfg.frac_bits    = frac_bits_q;
	assign cfg.ln2_constant = ln2_q & WMASK;

endmodule
`default_nettype wire

@@ src/fpmdl_queue.sv @@
`default_nettype none
module fpmdl_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  fpmdl_pkg::job_t     wr_job,
	input  wire                 pop,
	output fpmdl_pkg::job_t     rd_job,
	output logic                empty,
	output logic                full
);

	fpmdl_pkg::job_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wr_job;
	end

	assign rd_job = entry_q[rd_ptr_q];
	assign empty  = (count_q == 2'd0);
	assign full   = (count_q == 2'd2);

endmodule
`default_nettype wire

@@ src/fpmdl_back.sv @@
`default_nettype none
module fpmdl_back #(
	parameter int WORD_WIDTH = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 empty,
	input  fpmdl_pkg::job_t     job,
	input  fpmdl_pkg::cfg_t     cfg,
	output logic                pop,
	output logic                done,
	output fpmdl_pkg::rsp_t     rsp
);

	localparam logic [63:0]  WMASK  = {64{1'b1}} >> (64 - WORD_WIDTH);
	localparam logic [127:0] W2MASK = {128{1'b1}} >> (128 - 2 * WORD_WIDTH);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_NORM = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_SQ   = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t       state_q;
	logic         done_q;
	logic [2:0]   mstep_q;
	logic [6:0]   cnt_q;
	logic [6:0]   iter_q;
	logic         fin_q;
	logic [5:0]   m_q;

	logic [1:0]   func_q;
	logic [63:0]  ma_q, mb_q, pp_q;
	logic [1:0]   ppsel_q;
	logic [127:0] acc_q, n_q;
	logic [63:0]  rem_q, quo_q, x_q, y_q, w_q;
	logic [63:0]  job_b_q;
	fpmdl_pkg::rsp_t rsp_q;

	logic [6:0]   p;
	logic [31:0]  op_a, op_b;
	logic [127:0] pp_ext;
	logic         carry;
	logic [63:0]  r2;
	logic         take;
	logic [6:0]   pm, mp;
	logic [63:0]  z_norm, y_norm;
	logic         sq_hi;
	logic [63:0]  z_sq;
	logic [63:0]  y_sq;
	logic [63:0]  fin_res;

	assign p   = cfg.frac_bits;
	assign pop = (state_q == ST_IDLE) && !empty;

	// partial-product operand select
	always_comb begin
		case (mstep_q[1:0])
			2'd0:    begin op_a = ma_q[31:0];  op_b = mb_q[31:0];  end
			2'd1:    begin op_a = ma_q[31:0];  op_b = mb_q[63:32]; end
			2'd2:    begin op_a = ma_q[63:32]; op_b = mb_q[31:0];  end
			default: begin op_a = ma_q[63:32]; op_b = mb_q[63:32]; end
		endcase
		case (ppsel_q)
			2'd0:    pp_ext = {64'd0, pp_q};
			2'd3:    pp_ext = {pp_q, 64'd0};
			default: pp_ext = {32'd0, pp_q, 32'd0};
		endcase
	end

	// restoring divide step
	assign carry = rem_q[63];
	assign r2    = {rem_q[62:0], n_q[cnt_q]};
	assign take  = carry || (r2 >= job_b_q);

	// normalization to [1,2)
	assign pm     = p - {1'b0, m_q};
	assign mp     = {1'b0, m_q} - p;
	assign z_norm = ({1'b0, m_q} < p) ? (x_q << pm) : (x_q >> mp);
	assign y_norm = ({1'b0, m_q} < p) ? (64'd0 - (64'(pm) << p)) : (64'(mp) << p);

	// squaring update
	assign sq_hi = acc_q[{p[5:0], 1'b1}];
	assign z_sq  = sq_hi ? 64'(acc_q >> (p + 7'd1)) : 64'(acc_q >> p);
	assign y_sq  = sq_hi ? (y_q + w_q) : y_q;

	assign fin_res = 64'(acc_q >> p) & WMASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			mstep_q <= 3'd0;
			cnt_q   <= 7'd0;
			iter_q  <= 7'd0;
			fin_q   <= 1'b0;
			m_q     <= 6'd0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						if (job.status != fpmdl_pkg::STATUS_OK) begin
							done_q <= 1'b1;
						end else begin
							case (job.func)
								fpmdl_pkg::FUNC_MUL: begin
									mstep_q <= 3'd0;
									fin_q   <= 1'b1;
									state_q <= ST_MUL;
								end
								fpmdl_pkg::FUNC_DIV: begin
									cnt_q   <= 7'(2 * WORD_WIDTH - 1);
									state_q <= ST_DIV;
								end
								default: begin
									m_q     <= 6'd63;
									state_q <= ST_NORM;
								end
							endcase
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_NORM: begin
					if (x_q[m_q]) begin
						iter_q  <= p;
						mstep_q <= 3'd0;
						fin_q   <= 1'b0;
						state_q <= ST_MUL;
					end else begin
						m_q <= m_q - 6'd1;
					end
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd4) state_q <= fin_q ? ST_FIN : ST_SQ;
				end
				ST_SQ: begin
					iter_q  <= iter_q - 7'd1;
					mstep_q <= 3'd0;
					if (iter_q == 7'd1) begin
						if (func_q == fpmdl_pkg::FUNC_LOG2) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							fin_q   <= 1'b1;
							state_q <= ST_MUL;
						end
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					func_q  <= job.func;
					ma_q    <= job.a;
					mb_q    <= job.b;
					job_b_q <= job.b;
					x_q     <= job.a;
					acc_q   <= 128'd0;
					rem_q   <= 64'd0;
					quo_q   <= 64'd0;
					n_q     <= ({64'd0, job.a} << p) & W2MASK;
					rsp_q.result <= WMASK;
					rsp_q.status <= job.status;
				end
			end
			ST_DIV: begin
				rem_q <= take ? (r2 - job_b_q) : r2;
				quo_q <= {quo_q[62:0], take};
				if (cnt_q == 7'd0) begin
					rsp_q.result <= {quo_q[62:0], take} & WMASK;
					rsp_q.status <= fpmdl_pkg::STATUS_OK;
				end
			end
			ST_NORM: begin
				if (x_q[m_q]) begin
					ma_q  <= z_norm;
					mb_q  <= z_norm;
					y_q   <= y_norm;
					w_q   <= 64'd1 << (p - 7'd1);
					acc_q <= 128'd0;
				end
			end
			ST_MUL: begin
				if (mstep_q != 3'd4) begin
					pp_q    <= op_a * op_b;
					ppsel_q <= mstep_q[1:0];
				end
				if (mstep_q != 3'd0) acc_q <= acc_q + pp_ext;
			end
			ST_SQ: begin
				y_q   <= y_sq;
				w_q   <= w_q >> 1;
				acc_q <= 128'd0;
				if (iter_q == 7'd1) begin
					ma_q <= (64'd0 - y_sq) & WMASK;
					mb_q <= cfg.ln2_constant;
					rsp_q.result <= y_sq & WMASK;
					rsp_q.status <= fpmdl_pkg::STATUS_OK;
				end else begin
					ma_q <= z_sq;
					mb_q <= z_sq;
				end
			end
			ST_FIN: begin
				rsp_q.result <= fin_res;
				rsp_q.status <= fpmdl_pkg::STATUS_OK;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

@@ src/fixed_point_mul_div_log_unit_core.sv @@
`default_nettype none
// Unsigned fixed-point multiply / divide / log2 / negated-ln unit.
// Command channel: drive cmd with start high; the beat is taken at a clock
// edge where busy is low. Up to two commands are held in a queue ahead of
// the execution unit, so busy only rises when that queue is full.
// Result channel: done pulses for one cycle with rsp valid; the receiver
// cannot hold results off, so it must take every beat on that cycle.
// Results leave in command order, exactly one per command.
// Configuration: cfg_we writes register cfg_index (0 fraction bits,
// 1 ln2 constant) from cfg_data; write only while the unit is idle.
// Steps per command, once it leaves the queue: multiply as four partial
//   products, divide one quotient bit a cycle, log2 a normalize scan then
//   one squaring per fraction bit (each squaring runs four 32x32 partial
//   products through the single multiplier), negated ln as log2 plus a
//   multiply by the ln2 constant; flagged errors finish from idle.
// Reset clears the queue and the sequencer and loads 32 fraction bits and
// the default ln2 constant; nothing is in flight afterward.
module fixed_point_mul_div_log_unit_core #(
	parameter int WORD_WIDTH = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  fpmdl_pkg::cmd_t     cmd,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire  [63:0]         cfg_data,
	output logic                done,
	output fpmdl_pkg::rsp_t     rsp
);

	fpmdl_pkg::job_t push_job;
	fpmdl_pkg::job_t head_job;
	fpmdl_pkg::cfg_t cfg;
	logic push, pop, empty, full;

	// front: take commands, hold config, flag error cases
	fpmdl_front #(.WORD_WIDTH(WORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.full      (full),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.job       (push_job),
		.cfg       (cfg)
	);

	// short queue decouples acceptance from execution
	fpmdl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.rd_job (head_job),
		.empty  (empty),
		.full   (full)
	);

	// back: sequenced multiply, divide and log datapath
	fpmdl_back #(.WORD_WIDTH(WORD_WIDTH)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.job    (head_job),
		.cfg    (cfg),
		.pop    (pop),
		.done   (done),
		.rsp    (rsp)
	);

	assign busy = full;

endmodule
`default_nettype wire

@@ src/fpmdl_checker.sv @@
`default_nettype none
`include "fixed_point_mul_div_log_unit_core_macros.svh"
module fpmdl_checker #(
	parameter int WORD_WIDTH = 64
) (
	input wire              clk,
	input wire              arst_n,
	input wire              start,
	input wire              busy,
	input wire              done,
	input fpmdl_pkg::rsp_t  rsp
);

	localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - WORD_WIDTH);

	logic flagged;
	logic code_ok;

	assign flagged = done && (rsp.status != fpmdl_pkg::STATUS_OK);
	assign code_ok = (rsp.status <= fpmdl_pkg::STATUS_LOGERR);

	// no status code beyond the defined ones
	`FPMDL_ASSERT_IMP(a_status_code, clk, arst_n, done, code_ok, "bad status")
	// flagged results carry all ones
	`FPMDL_ASSERT_IMP(a_err_ones, clk, arst_n, flagged, rsp.result == WMASK, "error not all ones")
	// result stays within the word
	`FPMDL_ASSERT_IMP(a_width, clk, arst_n, done, (rsp.result & ~WMASK) == 64'd0, "wide result")
	// queue cannot fill without a new command
	`FPMDL_ASSERT_NXT(a_busy_hold, clk, arst_n, !busy && !start, !busy, "busy without command")

endmodule

bind fixed_point_mul_div_log_unit_core fpmdl_checker #(.WORD_WIDTH(WORD_WIDTH)) u_fpmdl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
`default_nettype wire
